>>> hw/rtl/rgbwpd_pkg.sv
`default_nettype none
package rgbwpd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_FSCALE = 2'd1;
  localparam logic [1:0] CFG_INVERT = 2'd2;

  // hue sectors: leading / trailing channel
  localparam logic [1:0] SEC_RG = 2'd0;
  localparam logic [1:0] SEC_GB = 2'd1;
  localparam logic [1:0] SEC_BR = 2'd2;

  // hue in 1/64 degree
  localparam logic [14:0] SECTOR_UNITS = 15'd7680;
  localparam logic [14:0] HUE_LIMIT    = 15'd23040;

  localparam logic [16:0] FRAC_ONE = 17'h10000;

  localparam longint unsigned THIRD_PI_Q30 = 64'd1124419809;
  localparam longint unsigned ONE_Q30      = 64'd1073741824;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [7:0]  level_red;
    logic [7:0]  level_green;
    logic [7:0]  level_blue;
    logic [7:0]  level_white;
    logic [15:0] duty_red;
    logic [15:0] duty_green;
    logic [15:0] duty_blue;
    logic [15:0] duty_white;
  } rgbw_t;

  // values that ride along the hue divider
  typedef struct packed {
    logic [7:0] mn;
    logic [9:0] chroma;
  } side_t;

  // shift-subtract quotient, elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cosine in Q2.30 by a truncated Taylor series, elaboration only
  function automatic longint cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint          acc;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int k = 1; k <= 12; k++) begin
      dv   = 64'((2 * k - 1) * (2 * k));
      term = udiv64((term * x2) >> 30, dv);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  // split fraction for one table entry, (1 + cos t / cos(60 - t)) / 3 in Q1.16
  function automatic logic [16:0] split_entry(input int unsigned idx,
                                              input int unsigned bits);
    longint unsigned t;
    longint unsigned a;
    longint unsigned q;
    longint unsigned wi;
    longint          ct;
    longint          cb;
    longint          s;
    wi = 64'(idx);
    t  = (wi * 64'd2 * THIRD_PI_Q30) >> bits;
    a  = (t > THIRD_PI_Q30) ? t - THIRD_PI_Q30 : THIRD_PI_Q30 - t;
    ct = cos_q30(t);
    cb = cos_q30(a);
    s  = ct + cb;
    if (cb <= 0 || s <= 0) begin
      return 17'd0;
    end
    q = udiv64($unsigned(s) << 16, 64'd3 * $unsigned(cb));
    return (q > 64'h10000) ? FRAC_ONE : 17'(q);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rgbwpd_stream_if.sv
`default_nettype none
interface rgbwpd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rgbwpd_div_steps.sv
`default_nettype none
// A few restoring division steps; rem_i < den_i on entry.
module rgbwpd_div_steps #(
  parameter int DW    = 8,
  parameter int QW    = 16,
  parameter int STEPS = 4
) (
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [QW-1:0] low_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [DW-1:0] rem_o,
  output logic      [QW-1:0] low_o
);

  always_comb begin
    logic [DW:0]   tmp;
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    rem = rem_i;
    low = low_i;
    tmp = '0;
    for (int i = 0; i < STEPS; i++) begin
      tmp = {rem, low[QW-1]};
      low = {low[QW-2:0], 1'b0};
      if (tmp >= {1'b0, den_i}) begin
        tmp    = tmp - {1'b0, den_i};
        low[0] = 1'b1;
      end
      rem = tmp[DW-1:0];
    end
    rem_o = rem;
    low_o = low;
  end

endmodule
`default_nettype wire

>>> hw/rtl/rgbwpd_split_rom.sv
`default_nettype none
module rgbwpd_split_rom #(
  parameter int BITS = 10
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [BITS-1:0] idx,
  output logic      [16:0]     frac
);

  localparam int DEPTH = 2 ** BITS;

  logic [16:0] tbl [DEPTH];
  logic [16:0] frac_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    localparam logic [16:0] ENTRY = rgbwpd_pkg::split_entry(i, BITS);
    assign tbl[i] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac_r <= tbl[idx];
    end
  end

  assign frac = frac_r;

endmodule
`default_nettype wire

>>> hw/rtl/rgb_to_rgbw_pwm_duty_unit.sv
`default_nettype none
// channel | dir | beat payload                              | handshake
// in_s    | in  | red_in, green_in, blue_in                 | valid/ready
// out_s   | out | level_red..level_white, duty_red..white   | valid/ready
// cfg_*   | in  | cfg_idx selects register, cfg_wdata value | cfg_we, no wait
//
// One beat per cycle sustained while out_s keeps taking beats, through a 15-stage
// pipeline (hue divider 6, sector/table/split 4, duty divider 5).
// The whole pipeline advances together: it holds when the last stage has a
// beat that out_s has not taken, and in_s.ready follows that.
// Reset clears the valid bits and loads period 20000, full scale 255, no invert.
module rgb_to_rgbw_pwm_duty_unit #(
  parameter int ANGLE_TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rgbwpd_stream_if.sink    in_s,
  rgbwpd_stream_if.source  out_s,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NSTG = 15;
  localparam int XW   = ANGLE_TABLE_BITS + 4;
  localparam int RS   = ANGLE_TABLE_BITS + 12;
  localparam int MW   = RS - 3;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RS) + 64'd14) / 64'd15);

  // configuration
  logic [15:0] period_r;
  logic [7:0]  fscale_r;
  logic        invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd20000;
      fscale_r <= 8'd255;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        rgbwpd_pkg::CFG_PERIOD: period_r <= cfg_wdata;
        rgbwpd_pkg::CFG_FSCALE: fscale_r <= cfg_wdata[7:0];
        rgbwpd_pkg::CFG_INVERT: invert_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [7:0] den_duty;
  assign den_duty = (fscale_r == 8'd0) ? 8'd1 : fscale_r;

  // pipeline control
  logic [NSTG-1:0] v_r;
  logic            en;

  assign en         = !v_r[NSTG-1] || out_s.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_s.valid};
    end
  end

  // front: min, max, chroma and hue numerator
  logic [7:0]  r_in, g_in, b_in, mx, mn, dd;
  logic [11:0] hsum;
  logic [22:0] hnum;
  logic [7:0]  hden;
  logic [9:0]  chroma;

  assign r_in = in_s.data.red_in;
  assign g_in = in_s.data.green_in;
  assign b_in = in_s.data.blue_in;

  always_comb begin
    mx = r_in;
    if (g_in > mx) mx = g_in;
    if (b_in > mx) mx = b_in;
    mn = r_in;
    if (g_in < mn) mn = g_in;
    if (b_in < mn) mn = b_in;
    dd = mx - mn;
    if (mx == b_in) begin
      hsum = {2'b0, dd, 2'b0} + 12'(r_in) - 12'(g_in);
    end else if (mx == g_in) begin
      hsum = {3'b0, dd, 1'b0} + 12'(b_in) - 12'(r_in);
    end else if (g_in >= b_in) begin
      hsum = 12'(g_in) - 12'(b_in);
    end else begin
      hsum = {2'b0, dd, 2'b0} + {3'b0, dd, 1'b0} + 12'(g_in) - 12'(b_in);
    end
    // times 3840 = 4096 - 256
    hnum = {hsum[10:0], 12'b0} - {4'b0, hsum[10:0], 8'b0};
    hden = dd;
    if (dd == 8'd0) begin
      hnum = '0;
      hden = 8'd1;
    end
    chroma = 10'(r_in) + 10'(g_in) + 10'(b_in) - {1'b0, mn, 1'b0} - 10'(mn);
  end

  // hue divider: 15 quotient bits, 3 per stage
  logic [7:0]          hrem_r  [6];
  logic [14:0]         hlow_r  [6];
  logic [7:0]          hden_r  [6];
  rgbwpd_pkg::side_t   hside_r [6];
  logic [7:0]          hrem_nxt [5];
  logic [14:0]         hlow_nxt [5];

  always_ff @(posedge clk) begin
    if (en) begin
      hrem_r[0]         <= hnum[22:15];
      hlow_r[0]         <= hnum[14:0];
      hden_r[0]         <= hden;
      hside_r[0].mn     <= mn;
      hside_r[0].chroma <= chroma;
    end
  end

  for (genvar k = 0; k < 5; k++) begin : g_hdiv
    rgbwpd_div_steps #(.DW(8), .QW(15), .STEPS(3)) u_steps (
      .rem_i (hrem_r[k]),
      .low_i (hlow_r[k]),
      .den_i (hden_r[k]),
      .rem_o (hrem_nxt[k]),
      .low_o (hlow_nxt[k])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        hrem_r[k+1]  <= hrem_nxt[k];
        hlow_r[k+1]  <= hlow_nxt[k];
        hden_r[k+1]  <= hden_r[k];
        hside_r[k+1] <= hside_r[k];
      end
    end
  end

  // sector and angle within it
  logic [14:0]       hue;
  logic [1:0]        sec_nxt;
  logic [14:0]       within_nxt;
  logic [1:0]        sec7_r, sec8_r, sec9_r;
  logic [12:0]       within7_r;
  rgbwpd_pkg::side_t side7_r, side8_r, side9_r;

  assign hue = hlow_r[5];

  always_comb begin
    if (hue >= {rgbwpd_pkg::SECTOR_UNITS[13:0], 1'b0}) begin
      sec_nxt    = rgbwpd_pkg::SEC_BR;
      within_nxt = hue - {rgbwpd_pkg::SECTOR_UNITS[13:0], 1'b0};
    end else if (hue >= rgbwpd_pkg::SECTOR_UNITS) begin
      sec_nxt    = rgbwpd_pkg::SEC_GB;
      within_nxt = hue - rgbwpd_pkg::SECTOR_UNITS;
    end else begin
      sec_nxt    = rgbwpd_pkg::SEC_RG;
      within_nxt = hue;
    end
  end

  // table index = within * 2^bits / 7680 = (within * 2^bits / 512) / 15
  logic [ANGLE_TABLE_BITS+12:0] wsh;
  logic [XW-1:0]                xq;
  logic [XW+MW-1:0]             xprod;
  logic [ANGLE_TABLE_BITS-1:0]  idx8_r;

  assign wsh   = {within7_r, ANGLE_TABLE_BITS'(0)} >> 9;
  assign xq    = wsh[XW-1:0];
  assign xprod = (XW+MW)'(xq) * (XW+MW)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      sec7_r    <= sec_nxt;
      within7_r <= within_nxt[12:0];
      side7_r   <= hside_r[5];
      idx8_r    <= xprod[RS+ANGLE_TABLE_BITS-1:RS];
      sec8_r    <= sec7_r;
      side8_r   <= side7_r;
      sec9_r    <= sec8_r;
      side9_r   <= side8_r;
    end
  end

  logic [16:0] frac;

  rgbwpd_split_rom #(.BITS(ANGLE_TABLE_BITS)) u_rom (
    .clk  (clk),
    .en   (en),
    .idx  (idx8_r),
    .frac (frac)
  );

  // split chroma between leading and trailing channel
  logic [26:0] lead_p, trail_p;
  logic [7:0]  lead, trail;
  logic [7:0]  lv_nxt [4];
  logic [7:0]  lvl10_r [4];

  assign lead_p  = 27'(side9_r.chroma) * 27'(frac);
  assign trail_p = 27'(side9_r.chroma) * 27'(rgbwpd_pkg::FRAC_ONE - frac);
  assign lead    = (lead_p[26:16] > 11'd255) ? 8'd255 : lead_p[23:16];
  assign trail   = (trail_p[26:16] > 11'd255) ? 8'd255 : trail_p[23:16];

  always_comb begin
    lv_nxt[0] = 8'd0;
    lv_nxt[1] = 8'd0;
    lv_nxt[2] = 8'd0;
    lv_nxt[3] = side9_r.mn;
    case (sec9_r)
      rgbwpd_pkg::SEC_RG: begin
        lv_nxt[0] = lead;
        lv_nxt[1] = trail;
      end
      rgbwpd_pkg::SEC_GB: begin
        lv_nxt[1] = lead;
        lv_nxt[2] = trail;
      end
      default: begin
        lv_nxt[2] = lead;
        lv_nxt[0] = trail;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lvl10_r <= lv_nxt;
    end
  end

  // duty = period * level / full_scale, 16 quotient bits, 4 per stage
  logic [7:0]  drem_r [5][4];
  logic [15:0] dlow_r [5][4];
  logic        dsat_r [5][4];
  logic [7:0]  dlvl_r [5][4];
  logic [7:0]  drem_nxt [4][4];
  logic [15:0] dlow_nxt [4][4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [7:0]  lsel;
    logic [23:0] dprod;
    logic        sat;

    assign lsel  = invert_r ? (8'd255 - lvl10_r[j]) : lvl10_r[j];
    assign dprod = 24'(period_r) * 24'(lsel);
    assign sat   = dprod[23:16] >= den_duty;

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[0][j] <= sat ? 8'd0 : dprod[23:16];
        dlow_r[0][j] <= dprod[15:0];
        dsat_r[0][j] <= sat;
        dlvl_r[0][j] <= lvl10_r[j];
      end
    end

    for (genvar k = 0; k < 4; k++) begin : g_ddiv
      rgbwpd_div_steps #(.DW(8), .QW(16), .STEPS(4)) u_steps (
        .rem_i (drem_r[k][j]),
        .low_i (dlow_r[k][j]),
        .den_i (den_duty),
        .rem_o (drem_nxt[k][j]),
        .low_o (dlow_nxt[k][j])
      );

      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[k+1][j] <= drem_nxt[k][j];
          dlow_r[k+1][j] <= dlow_nxt[k][j];
          dsat_r[k+1][j] <= dsat_r[k][j];
          dlvl_r[k+1][j] <= dlvl_r[k][j];
        end
      end
    end
  end

  assign out_s.valid            = v_r[NSTG-1];
  assign out_s.data.level_red   = dlvl_r[4][0];
  assign out_s.data.level_green = dlvl_r[4][1];
  assign out_s.data.level_blue  = dlvl_r[4][2];
  assign out_s.data.level_white = dlvl_r[4][3];
  assign out_s.data.duty_red    = dsat_r[4][0] ? 16'hFFFF : dlow_r[4][0];
  assign out_s.data.duty_green  = dsat_r[4][1] ? 16'hFFFF : dlow_r[4][1];
  assign out_s.data.duty_blue   = dsat_r[4][2] ? 16'hFFFF : dlow_r[4][2];
  assign out_s.data.duty_white  = dsat_r[4][3] ? 16'hFFFF : dlow_r[4][3];

  // a held pipeline keeps its beats in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] |-> hlow_r[5] < rgbwpd_pkg::HUE_LIMIT)
    else $error("hue quotient out of range");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] |-> sec7_r != 2'd3)
    else $error("invalid hue sector");

  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[8] |-> frac <= rgbwpd_pkg::FRAC_ONE)
    else $error("split fraction above one");

endmodule
`default_nettype wire
